// ----- hdl/particle_euler_integrator_box_reflect_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the particle integrator
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_EULER_INTEGRATOR_BOX_REFLECT_MACROS_SVH
`define PARTICLE_EULER_INTEGRATOR_BOX_REFLECT_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define PEIBR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("peibr assertion failed");
// antecedent implies consequent in the next cycle
`define PEIBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("peibr assertion failed");
`else
`define PEIBR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PEIBR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/peibr_pkg.sv -----
// ----------------------------------------------------------------------------
// peibr_pkg
// Shared widths, register indexes, reset values and saturation helpers.
// ----------------------------------------------------------------------------
package peibr_pkg;

	localparam int unsigned VAL_W    = 32;
	localparam int unsigned DT_W     = 24;
	localparam int unsigned BOUND_W  = 31;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned NUM_AXES = 2;
	localparam int unsigned PROD_W   = VAL_W + DT_W + 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_HALF   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MODE = 8'd3;

	// reset values: dt about 1/240, box 20.0, gravity -10.0
	localparam logic [DT_W-1:0]           RST_STEP_SIZE = 24'd69905;
	localparam logic [BOUND_W-1:0]        RST_BOX_HALF  = 31'd1310720;
	localparam logic signed [VAL_W-1:0]   RST_GRAVITY   = -32'sd655360;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef enum logic {
		ACC_GRAVITY = 1'b0,
		ACC_ITEM    = 1'b1
	} accel_mode_t;

	// settings shared by every lane
	typedef struct packed {
		logic [DT_W-1:0]    dt;
		logic [BOUND_W-1:0] bound;
	} lane_cfg_t;

	// clamp a 34 bit sum into the 32 bit range
	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [VAL_W+1:0] v);
		logic signed [VAL_W-1:0] r;
		if ((v[VAL_W+1:VAL_W-1] == 3'b000) || (v[VAL_W+1:VAL_W-1] == 3'b111)) begin
			r = v[VAL_W-1:0];
		end else if (v[VAL_W+1]) begin
			r = VAL_MIN;
		end else begin
			r = VAL_MAX;
		end
		return r;
	endfunction

	// negation that maps the most negative value to the most positive
	function automatic logic signed [VAL_W-1:0] neg_sat(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v == VAL_MIN) begin
			r = VAL_MAX;
		end else begin
			r = -v;
		end
		return r;
	endfunction

endpackage

// ----- hdl/peibr_if.sv -----
// ----------------------------------------------------------------------------
// peibr interfaces
// Valid/ready channels for particle items, results and register writes.
// ----------------------------------------------------------------------------
interface peibr_item_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [peibr_pkg::VAL_W-1:0]    pos_x;
	logic signed [peibr_pkg::VAL_W-1:0]    pos_y;
	logic signed [peibr_pkg::VAL_W-1:0]    vel_x;
	logic signed [peibr_pkg::VAL_W-1:0]    vel_y;
	logic signed [peibr_pkg::VAL_W-1:0]    acc_x;
	logic signed [peibr_pkg::VAL_W-1:0]    acc_y;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, input ready);
	modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, output ready);
endinterface

interface peibr_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [peibr_pkg::VAL_W-1:0]    next_pos_x;
	logic signed [peibr_pkg::VAL_W-1:0]    next_pos_y;
	logic signed [peibr_pkg::VAL_W-1:0]    next_vel_x;
	logic signed [peibr_pkg::VAL_W-1:0]    next_vel_y;

	modport source (output valid, next_pos_x, next_pos_y, next_vel_x, next_vel_y, input ready);
	modport sink   (input valid, next_pos_x, next_pos_y, next_vel_x, next_vel_y, output ready);
endinterface

interface peibr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [peibr_pkg::CFG_IDX_W-1:0]    index;
	logic [peibr_pkg::VAL_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/peibr_lane.sv -----
// ----------------------------------------------------------------------------
// peibr_lane
// One axis of the integrator: v' = v + a*dt, p' = p + v'*dt, wall reflect.
// ----------------------------------------------------------------------------
module peibr_lane (
	input  logic                                clk,
	input  logic                                en,
	input  peibr_pkg::lane_cfg_t                cfg,
	input  logic signed [peibr_pkg::VAL_W-1:0]  pos,
	input  logic signed [peibr_pkg::VAL_W-1:0]  vel,
	input  logic signed [peibr_pkg::VAL_W-1:0]  acc,
	output logic signed [peibr_pkg::VAL_W-1:0]  next_pos,
	output logic signed [peibr_pkg::VAL_W-1:0]  next_vel
);

	localparam int unsigned W  = peibr_pkg::VAL_W;
	localparam int unsigned PW = peibr_pkg::PROD_W;
	localparam int unsigned SH = peibr_pkg::DT_W;

	logic signed [PW-1:0] prod_a_s1;
	logic signed [W-1:0]  pos_s1, vel_s1;
	logic signed [W-1:0]  pos_s2, vel_s2;
	logic signed [PW-1:0] prod_v_s3;
	logic signed [W-1:0]  pos_s3, vel_s3;
	logic signed [W-1:0]  pos_s4, vel_s4;
	logic signed [W-1:0]  pos_s5, vel_s5;

	logic signed [PW-1:0] prod_a, prod_v;
	logic signed [W+1:0]  vsum, psum;
	logic signed [W:0]    bound_pos, bound_neg, pos_ext;
	logic signed [W-1:0]  pos_clamp, vel_clamp;

	// products with dt; dt is zero-extended so it stays unsigned
	assign prod_a = acc * $signed({1'b0, cfg.dt});
	assign prod_v = vel_s2 * $signed({1'b0, cfg.dt});

	// sums of the shifted products, floor rounding via the arithmetic shift
	assign vsum = $signed({{2{vel_s1[W-1]}}, vel_s1})
		+ $signed({prod_a_s1[PW-1], prod_a_s1[PW-1:SH]});
	assign psum = $signed({{2{pos_s3[W-1]}}, pos_s3})
		+ $signed({prod_v_s3[PW-1], prod_v_s3[PW-1:SH]});

	// wall test: lower wall first; after it the upper wall cannot trigger
	assign bound_pos = $signed({2'b00, cfg.bound});
	assign bound_neg = -bound_pos;
	assign pos_ext   = $signed({pos_s4[W-1], pos_s4});

	always_comb begin
		pos_clamp = pos_s4;
		vel_clamp = vel_s4;
		if (pos_ext < bound_neg) begin
			pos_clamp = bound_neg[W-1:0];
			vel_clamp = peibr_pkg::neg_sat(vel_s4);
		end else if (pos_ext > bound_pos) begin
			pos_clamp = bound_pos[W-1:0];
			vel_clamp = peibr_pkg::neg_sat(vel_s4);
		end
	end

	// five payload stages, all moving together on en
	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s1 <= prod_a;
			pos_s1    <= pos;
			vel_s1    <= vel;
			pos_s2    <= pos_s1;
			vel_s2    <= peibr_pkg::sat32(vsum);
			prod_v_s3 <= prod_v;
			pos_s3    <= pos_s2;
			vel_s3    <= vel_s2;
			pos_s4    <= peibr_pkg::sat32(psum);
			vel_s4    <= vel_s3;
			pos_s5    <= pos_clamp;
			vel_s5    <= vel_clamp;
		end
	end

	assign next_pos = pos_s5;
	assign next_vel = vel_s5;

endmodule

// ----- hdl/peibr_merge.sv -----
// ----------------------------------------------------------------------------
// peibr_merge
// Gathers the lane results into one output transaction and holds it.
// ----------------------------------------------------------------------------
module peibr_merge (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                lane_valid,
	input  logic signed [peibr_pkg::VAL_W-1:0]  lane_pos [peibr_pkg::NUM_AXES],
	input  logic signed [peibr_pkg::VAL_W-1:0]  lane_vel [peibr_pkg::NUM_AXES],
	output logic                                advance,
	peibr_result_if.source                      res
);

	logic                               valid_q;
	logic signed [peibr_pkg::VAL_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;

	// pipeline moves whenever the output register is free or being drained
	assign advance = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= lane_valid;
		end
	end

	// lane 0 is x, lane 1 is y
	always_ff @(posedge clk) begin
		if (advance && lane_valid) begin
			pos_x_q <= lane_pos[0];
			pos_y_q <= lane_pos[1];
			vel_x_q <= lane_vel[0];
			vel_y_q <= lane_vel[1];
		end
	end

	assign res.valid      = valid_q;
	assign res.next_pos_x = pos_x_q;
	assign res.next_pos_y = pos_y_q;
	assign res.next_vel_x = vel_x_q;
	assign res.next_vel_y = vel_y_q;

endmodule

// ----- hdl/particle_euler_integrator_box_reflect.sv -----
// ----------------------------------------------------------------------------
// particle_euler_integrator_box_reflect
// Semi-implicit Euler step of a 2D particle inside a reflecting box.
// ----------------------------------------------------------------------------
// Path from input transaction to result valid: 5 lane stages plus
// the output register. Throughput: one particle per cycle; the two
// axis lanes each hold two 32x25 multipliers in separate stages.
// Stalls only when the output register is full and not being taken.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the
// register defaults: dt 69905, box 20.0, gravity -10.0, gravity mode.
module particle_euler_integrator_box_reflect (
	input  logic              clk,
	input  logic              arst_n,
	peibr_item_if.sink        in_item,
	peibr_result_if.source    out_res,
	peibr_cfg_if.sink         cfg
);

`include "particle_euler_integrator_box_reflect_macros.svh"

	localparam int unsigned W      = peibr_pkg::VAL_W;
	localparam int unsigned NA     = peibr_pkg::NUM_AXES;
	localparam int unsigned STAGES = 5;

	logic [peibr_pkg::DT_W-1:0]    step_size_q;
	logic [peibr_pkg::BOUND_W-1:0] box_half_q;
	logic signed [W-1:0]           gravity_q;
	peibr_pkg::accel_mode_t        accel_mode_q;

	peibr_pkg::lane_cfg_t lane_cfg;
	logic                 advance;
	logic [STAGES-1:0]    vld_q;
	logic signed [W-1:0]  lane_pos_in [NA];
	logic signed [W-1:0]  lane_vel_in [NA];
	logic signed [W-1:0]  lane_acc_in [NA];
	logic signed [W-1:0]  lane_pos_out [NA];
	logic signed [W-1:0]  lane_vel_out [NA];

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q  <= peibr_pkg::RST_STEP_SIZE;
			box_half_q   <= peibr_pkg::RST_BOX_HALF;
			gravity_q    <= peibr_pkg::RST_GRAVITY;
			accel_mode_q <= peibr_pkg::ACC_GRAVITY;
		end else if (cfg.valid) begin
			case (cfg.index)
				peibr_pkg::CFG_STEP_SIZE:  step_size_q  <= cfg.data[peibr_pkg::DT_W-1:0];
				peibr_pkg::CFG_BOX_HALF:   box_half_q   <= cfg.data[peibr_pkg::BOUND_W-1:0];
				peibr_pkg::CFG_GRAVITY:    gravity_q    <= $signed(cfg.data);
				peibr_pkg::CFG_ACCEL_MODE: accel_mode_q <= peibr_pkg::accel_mode_t'(cfg.data[0]);
				default: ;
			endcase
		end
	end

	assign lane_cfg.dt    = step_size_q;
	assign lane_cfg.bound = box_half_q;

	// acceleration source per axis
	assign lane_pos_in[0] = in_item.pos_x;
	assign lane_pos_in[1] = in_item.pos_y;
	assign lane_vel_in[0] = in_item.vel_x;
	assign lane_vel_in[1] = in_item.vel_y;
	assign lane_acc_in[0] = (accel_mode_q == peibr_pkg::ACC_ITEM) ? in_item.acc_x : '0;
	assign lane_acc_in[1] = (accel_mode_q == peibr_pkg::ACC_ITEM) ? in_item.acc_y : gravity_q;

	assign in_item.ready = advance;

	// valid bits that follow the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[STAGES-2:0], in_item.valid};
		end
	end

	for (genvar g = 0; g < NA; g++) begin : g_lane
		peibr_lane u_lane (
			.clk      (clk),
			.en       (advance),
			.cfg      (lane_cfg),
			.pos      (lane_pos_in[g]),
			.vel      (lane_vel_in[g]),
			.acc      (lane_acc_in[g]),
			.next_pos (lane_pos_out[g]),
			.next_vel (lane_vel_out[g])
		);
	end

	peibr_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_valid (vld_q[STAGES-1]),
		.lane_pos   (lane_pos_out),
		.lane_vel   (lane_vel_out),
		.advance    (advance),
		.res        (out_res)
	);

	// checks on the pipeline control
	`PEIBR_ASSERT_NEXT(a_accept_enters, clk, arst_n, in_item.valid && in_item.ready, vld_q[0])
	`PEIBR_ASSERT_SAME(a_stall_cause, clk, arst_n, !in_item.ready, out_res.valid && !out_res.ready)
	`PEIBR_ASSERT_NEXT(a_last_to_out, clk, arst_n, vld_q[STAGES-1] && advance, out_res.valid)
	`PEIBR_ASSERT_NEXT(a_stall_holds, clk, arst_n, vld_q[STAGES-1] && !advance, vld_q[STAGES-1])

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb - particle integrator testbench
// Streams 2D particles through the Euler step with reflecting walls and
// compares every result against a bit-accurate behavioural predictor.
// Random idle gaps on both channels and register changes between phases.
// ----------------------------------------------------------------------------
module tb;
	import peibr_pkg::*;

	typedef logic signed [VAL_W-1:0] fix_t;

	typedef struct packed {
		fix_t pos_x;
		fix_t pos_y;
		fix_t vel_x;
		fix_t vel_y;
		fix_t acc_x;
		fix_t acc_y;
	} particle_t;

	typedef struct packed {
		fix_t next_pos_x;
		fix_t next_pos_y;
		fix_t next_vel_x;
		fix_t next_vel_y;
	} motion_t;

	localparam fix_t            FIX_ONE        = 32'sd65536;
	localparam int              PIPE_LATENCY   = 6;
	localparam int              WATCHDOG_LIMIT = 2000;
	localparam int              PHASES         = 8;
	localparam int              PHASE_ITEMS    = 215;
	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hff;

	logic clk;
	logic arst_n;

	peibr_item_if   item_ch ();
	peibr_result_if res_ch ();
	peibr_cfg_if    cfg_ch ();

	particle_euler_integrator_box_reflect u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (item_ch),
		.out_res (res_ch),
		.cfg     (cfg_ch)
	);

	// predictor copy of the registers
	logic [DT_W-1:0]    cur_dt;
	logic [BOUND_W-1:0] cur_bound;
	fix_t               cur_gravity;
	accel_mode_t        cur_mode;

	motion_t pending_motion[$];

	int  n_fail;
	int  n_sent;
	int  n_checked;
	int  n_writes;
	int  n_settings;
	int  idle_cycles;
	int  rx_wait;
	bit  tx_calm;
	bit  rx_calm;

	// clock
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic fix_t clip32(input longint v);
		if (v > longint'(VAL_MAX)) begin
			return VAL_MAX;
		end
		if (v < longint'(VAL_MIN)) begin
			return VAL_MIN;
		end
		return v[VAL_W-1:0];
	endfunction

	// floor(x * dt / 2^24)
	function automatic longint scaled_by_dt(input longint x);
		return (x * longint'(cur_dt)) >>> DT_W;
	endfunction

	// velocity first, then position, then lower wall and upper wall
	function automatic void step_axis(input longint p, input longint v, input longint a,
			output fix_t np_o, output fix_t nv_o);
		longint b;
		longint nv;
		longint np;
		b  = longint'(cur_bound);
		nv = clip32(v + scaled_by_dt(a));
		np = clip32(p + scaled_by_dt(nv));
		if (np < -b) begin
			np = -b;
			nv = clip32(-nv);
		end
		if (np > b) begin
			np = b;
			nv = clip32(-nv);
		end
		np_o = np[VAL_W-1:0];
		nv_o = nv[VAL_W-1:0];
	endfunction

	function automatic motion_t predict_motion(input particle_t p);
		motion_t m;
		longint  ax;
		longint  ay;
		if (cur_mode == ACC_ITEM) begin
			ax = p.acc_x;
			ay = p.acc_y;
		end else begin
			ax = 0;
			ay = cur_gravity;
		end
		step_axis(p.pos_x, p.vel_x, ax, m.next_pos_x, m.next_vel_x);
		step_axis(p.pos_y, p.vel_y, ay, m.next_pos_y, m.next_vel_y);
		return m;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [VAL_W-1:0] data);
		case (idx)
			CFG_STEP_SIZE:  cur_dt      = data[DT_W-1:0];
			CFG_BOX_HALF:   cur_bound   = data[BOUND_W-1:0];
			CFG_GRAVITY:    cur_gravity = signed'(data);
			CFG_ACCEL_MODE: cur_mode    = accel_mode_t'(data[0]);
			default: ;
		endcase
	endfunction

	// mostly values around the box, some full-range and corner values
	function automatic fix_t pick_value(input logic [BOUND_W-1:0] span);
		longint          lim;
		longint unsigned u;
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 4))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			default: begin
				lim = longint'(span) + longint'(span) / 4 + 65536;
				u   = {$urandom, $urandom};
				return clip32(longint'(u % longint'(2 * lim + 1)) - lim);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// channel drivers
	// ------------------------------------------------------------------
	task automatic send_particle(input fix_t px, input fix_t py, input fix_t vx,
			input fix_t vy, input fix_t ax, input fix_t ay);
		int        gap;
		particle_t p;
		p = '{px, py, vx, vy, ax, ay};
		if ($urandom_range(0, 39) == 0) begin
			tx_calm = !tx_calm;
		end
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.pos_x <= px;
		item_ch.pos_y <= py;
		item_ch.vel_x <= vx;
		item_ch.vel_y <= vy;
		item_ch.acc_x <= ax;
		item_ch.acc_y <= ay;
		item_ch.valid <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		pending_motion.push_back(predict_motion(p));
		n_sent++;
	endtask

	// stop sending and let the pipeline empty
	task automatic settle_pipeline();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_motion.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		settle_pipeline();
		@(negedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, data);
		n_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// result back-pressure, one draw per result transaction
	always @(negedge clk) begin
		if (rx_wait > 0) begin
			res_ch.ready <= 1'b0;
			rx_wait--;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input fix_t want, input fix_t got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk) begin : result_checker
		motion_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_motion.size() == 0) begin
				$error("result transaction with no particle outstanding");
				n_fail++;
			end else begin
				want = pending_motion.pop_front();
				check_field("next_pos_x", want.next_pos_x, res_ch.next_pos_x);
				check_field("next_pos_y", want.next_pos_y, res_ch.next_pos_y);
				check_field("next_vel_x", want.next_vel_x, res_ch.next_vel_x);
				check_field("next_vel_y", want.next_vel_y, res_ch.next_vel_y);
			end
			n_checked++;
			if ($urandom_range(0, 39) == 0) begin
				rx_calm = !rx_calm;
			end
			rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// reset register values: dt 1/240, box 20.0, gravity -10.0
	task automatic test_reset_defaults();
		send_particle(0, 0, 0, 0, 0, 0);
		// acceleration fields ignored in gravity mode
		send_particle(5 * FIX_ONE, -3 * FIX_ONE, FIX_ONE, -FIX_ONE, VAL_MAX, VAL_MIN);
		send_particle(25 * FIX_ONE, 0, FIX_ONE, 0, 0, 0);
		send_particle(0, -25 * FIX_ONE, 0, -2 * FIX_ONE, 0, 0);
		send_particle(20 * FIX_ONE, -20 * FIX_ONE, 0, 0, 0, 0);
	endtask

	task automatic test_field_extremes();
		write_reg(CFG_ACCEL_MODE, 32'(ACC_ITEM));
		write_reg(CFG_STEP_SIZE, 32'h00ff_ffff);
		send_particle(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN);
		send_particle(VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX);
		// negative products round towards minus infinity
		send_particle(-1, 1, -1, 1, -1, 1);
		send_particle(0, 0, 0, 0, VAL_MAX, VAL_MIN);
		write_reg(CFG_BOX_HALF, 32'h7fff_ffff);
		send_particle(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN);
		write_reg(CFG_ACCEL_MODE, 32'(ACC_GRAVITY));
		write_reg(CFG_GRAVITY, VAL_MIN);
		send_particle(0, 0, 0, 0, 0, 0);
		write_reg(CFG_GRAVITY, VAL_MAX);
		send_particle(0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_special_cases();
		// zero box pins every position to the origin
		write_reg(CFG_STEP_SIZE, 32'(RST_STEP_SIZE));
		write_reg(CFG_BOX_HALF, 0);
		send_particle(FIX_ONE, -FIX_ONE, FIX_ONE, -FIX_ONE, 0, 0);
		send_particle(0, 0, 0, 0, 0, 0);
		// zero dt: reflection of the most negative velocity saturates
		write_reg(CFG_STEP_SIZE, 0);
		write_reg(CFG_BOX_HALF, 20 * FIX_ONE);
		write_reg(CFG_GRAVITY, 32'(RST_GRAVITY));
		send_particle(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, 0, 0);
		write_reg(CFG_ACCEL_MODE, 32'(ACC_ITEM));
		send_particle(VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN, 0, 0);
		// bits above each register's width and unused indexes are dropped
		write_reg(CFG_STEP_SIZE, 32'hff00_0001);
		write_reg(CFG_BOX_HALF, 32'h8000_0000 | (4 * FIX_ONE));
		write_reg(CFG_ACCEL_MODE, 32'hffff_fffe);
		write_reg(CFG_UNUSED_LO, 32'hffff_ffff);
		write_reg(CFG_UNUSED_HI, 32'h0000_0001);
		send_particle(3 * FIX_ONE, -5 * FIX_ONE, VAL_MAX, FIX_ONE, VAL_MAX, VAL_MAX);
		send_particle(-5 * FIX_ONE, 5 * FIX_ONE, -FIX_ONE, VAL_MAX, VAL_MIN, VAL_MIN);
	endtask

	task automatic test_random_phases();
		logic [VAL_W-1:0] dt_word;
		logic [VAL_W-1:0] box_word;
		logic [VAL_W-1:0] grav_word;
		logic [VAL_W-1:0] mode_word;
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				dt_word   = 32'h00ff_ffff;
				box_word  = 32'h7fff_ffff;
				grav_word = VAL_MIN;
				mode_word = 32'(ACC_ITEM);
			end else if (ph == 1) begin
				dt_word   = 1;
				box_word  = 0;
				grav_word = VAL_MAX;
				mode_word = 32'(ACC_GRAVITY);
			end else begin
				case ($urandom_range(0, 3))
					0: dt_word = 32'(RST_STEP_SIZE);
					1: dt_word = $urandom_range(1, 1 << 20);
					2: dt_word = $urandom;
					default: dt_word = 32'h00ff_ffff;
				endcase
				case ($urandom_range(0, 3))
					0: box_word = FIX_ONE * $urandom_range(1, 64);
					1: box_word = $urandom;
					2: box_word = 0;
					default: box_word = $urandom_range(0, 1 << 20);
				endcase
				case ($urandom_range(0, 2))
					0: grav_word = $urandom;
					1: grav_word = -(FIX_ONE * $urandom_range(0, 50));
					default: grav_word = 32'(RST_GRAVITY);
				endcase
				mode_word = $urandom;
			end
			write_reg(CFG_STEP_SIZE, dt_word);
			write_reg(CFG_BOX_HALF, box_word);
			write_reg(CFG_GRAVITY, grav_word);
			write_reg(CFG_ACCEL_MODE, mode_word);
			if ($urandom_range(0, 1) == 1) begin
				write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), $urandom);
			end
			n_settings++;
			repeat (PHASE_ITEMS) begin
				send_particle(pick_value(cur_bound), pick_value(cur_bound),
					pick_value(cur_bound), pick_value(cur_bound),
					pick_value(cur_bound), pick_value(cur_bound));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.pos_x = '0;
		item_ch.pos_y = '0;
		item_ch.vel_x = '0;
		item_ch.vel_y = '0;
		item_ch.acc_x = '0;
		item_ch.acc_y = '0;
		res_ch.ready  = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = '0;
		cfg_ch.data   = '0;
		cur_dt        = RST_STEP_SIZE;
		cur_bound     = RST_BOX_HALF;
		cur_gravity   = RST_GRAVITY;
		cur_mode      = ACC_GRAVITY;
		n_fail        = 0;
		n_sent        = 0;
		n_checked     = 0;
		n_writes      = 0;
		n_settings    = 0;
		idle_cycles   = 0;
		rx_wait       = 0;
		tx_calm       = 1'b0;
		rx_calm       = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_field_extremes();
		test_special_cases();
		test_random_phases();
		settle_pipeline();

		if (pending_motion.size() != 0) begin
			$error("%0d particles never produced a result", pending_motion.size());
			n_fail++;
		end
		$display("Run covered %0d particles, %0d results compared, %0d mismatches.",
			n_sent, n_checked, n_fail);
		$display("Register writes: %0d, random register settings: %0d.", n_writes, n_settings);
		if (n_fail == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/peibr_pkg.sv
hdl/peibr_if.sv
hdl/peibr_lane.sv
hdl/peibr_merge.sv
hdl/particle_euler_integrator_box_reflect.sv
sim/tb.sv
